FILE: design/eas_pkg.sv
// ----------------------------------------------------------------------------
// eas_pkg: shared definitions for the serial EEPROM access sequencer
// Phase codes, command codes, status codes and default settings.
// ----------------------------------------------------------------------------
package eas_pkg;

	localparam int ADDRESS_BITS_DEFAULT = 7;
	localparam int DATA_BITS_DEFAULT    = 8;
	localparam int OPCODE_BITS          = 3;
	localparam int STATUS_BITS          = 2;
	localparam int POLL_BITS            = 16;

	localparam logic [POLL_BITS-1:0] POLL_LIMIT_RESET = 16'd1000;

	localparam logic [OPCODE_BITS-1:0] OP_TICK  = 3'd0;
	localparam logic [OPCODE_BITS-1:0] OP_READ  = 3'd1;
	localparam logic [OPCODE_BITS-1:0] OP_WRITE = 3'd2;
	localparam logic [OPCODE_BITS-1:0] OP_EWEN  = 3'd3;
	localparam logic [OPCODE_BITS-1:0] OP_EWDS  = 3'd4;

	localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_NOSTART  = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_TIMEOUT  = 2'd2;

	// Two-bit opcode field sent on the wire after the start bit.
	localparam logic [1:0] WIRE_READ  = 2'b10;
	localparam logic [1:0] WIRE_WRITE = 2'b01;
	localparam logic [1:0] WIRE_MISC  = 2'b00;

	typedef enum logic [11:0] {
		PH_IDLE         = 12'b0000_0000_0001,
		PH_SHIFT        = 12'b0000_0000_0010,
		PH_DUMMY        = 12'b0000_0000_0100,
		PH_SAMPLE       = 12'b0000_0000_1000,
		PH_GAP          = 12'b0000_0001_0000,
		PH_CHECK1       = 12'b0000_0010_0000,
		PH_CHECK2       = 12'b0000_0100_0000,
		PH_CHECK3       = 12'b0000_1000_0000,
		PH_POLL         = 12'b0001_0000_0000,
		PH_DONE_OK      = 12'b0010_0000_0000,
		PH_DONE_NOSTART = 12'b0100_0000_0000,
		PH_DONE_TIMEOUT = 12'b1000_0000_0000
	} phase_t;

endpackage

FILE: design/eas_core.sv
// ----------------------------------------------------------------------------
// eas_core: bit-period sequencer
// Holds the command state and advances it by one serial bit period each time
// step is high, producing the driven lines and completion status.
// ----------------------------------------------------------------------------
module eas_core #(
	parameter int ADDRESS_BITS = eas_pkg::ADDRESS_BITS_DEFAULT,
	parameter int DATA_BITS    = eas_pkg::DATA_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [eas_pkg::OPCODE_BITS-1:0]  opcode,
	input  logic [ADDRESS_BITS-1:0]          address,
	input  logic [DATA_BITS-1:0]             write_data,
	input  logic                             data_in_pin,
	input  logic [eas_pkg::POLL_BITS-1:0]    poll_limit,
	output logic                             chip_select,
	output logic                             data_out_pin,
	output logic                             busy_res,
	output logic                             done_res,
	output logic [DATA_BITS-1:0]             read_data,
	output logic [eas_pkg::STATUS_BITS-1:0]  status
);

	localparam int SHIFT_BITS = 3 + ADDRESS_BITS + DATA_BITS;
	localparam int BCW        = $clog2(SHIFT_BITS + 1);
	localparam int PW         = eas_pkg::POLL_BITS;

	eas_pkg::phase_t                  phase_q, phase_d;
	logic [eas_pkg::OPCODE_BITS-1:0]  kind_q, kind_d;
	logic [SHIFT_BITS-1:0]            shift_out_q, shift_out_d;
	logic [BCW-1:0]                   bit_count_q, bit_count_d;
	logic [DATA_BITS-1:0]             shift_in_q, shift_in_d;
	logic [PW-1:0]                    poll_count_q, poll_count_d;

	always_comb begin
		eas_pkg::phase_t         ph;
		logic                    start;
		logic [1:0]              wire_op;
		logic [ADDRESS_BITS-1:0] field;
		logic [DATA_BITS-1:0]    data;
		logic [BCW-1:0]          bc_dec;
		logic [PW:0]             cnt;

		start   = (phase_q == eas_pkg::PH_IDLE) && (opcode inside
			{eas_pkg::OP_READ, eas_pkg::OP_WRITE, eas_pkg::OP_EWEN, eas_pkg::OP_EWDS});
		wire_op = eas_pkg::WIRE_MISC;
		field   = '0;
		data    = '0;
		case (opcode)
			eas_pkg::OP_READ: begin
				wire_op = eas_pkg::WIRE_READ;
				field   = address;
			end
			eas_pkg::OP_WRITE: begin
				wire_op = eas_pkg::WIRE_WRITE;
				field   = address;
				data    = write_data;
			end
			eas_pkg::OP_EWEN: begin
				field = {2'b11, {(ADDRESS_BITS-2){1'b0}}};
			end
			default: begin
				field = '0;
			end
		endcase

		// A command taken in idle shifts its start bit in the same period.
		ph            = phase_q;
		kind_d        = kind_q;
		shift_out_d   = shift_out_q;
		bit_count_d   = bit_count_q;
		shift_in_d    = shift_in_q;
		poll_count_d  = poll_count_q;
		if (start) begin
			ph           = eas_pkg::PH_SHIFT;
			kind_d       = opcode;
			shift_out_d  = {1'b1, wire_op, field, data};
			bit_count_d  = (opcode == eas_pkg::OP_WRITE) ? BCW'(SHIFT_BITS)
				: BCW'(3 + ADDRESS_BITS);
			shift_in_d   = '0;
			poll_count_d = '0;
		end

		bc_dec       = (bit_count_d != '0) ? bit_count_d - 1'b1 : '0;
		cnt          = {1'b0, poll_count_d} + 1'b1;
		phase_d      = ph;
		chip_select  = 1'b0;
		data_out_pin = 1'b0;
		busy_res     = 1'b1;
		done_res     = 1'b0;
		read_data    = '0;
		status       = eas_pkg::ST_OK;

		case (ph)
			eas_pkg::PH_SHIFT: begin
				chip_select  = 1'b1;
				data_out_pin = shift_out_d[SHIFT_BITS-1];
				shift_out_d  = {shift_out_d[SHIFT_BITS-2:0], 1'b0};
				bit_count_d  = bc_dec;
				if (bc_dec == '0) begin
					if (kind_d == eas_pkg::OP_READ)
						phase_d = eas_pkg::PH_DUMMY;
					else if (kind_d == eas_pkg::OP_WRITE)
						phase_d = eas_pkg::PH_GAP;
					else
						phase_d = eas_pkg::PH_DONE_OK;
				end
			end
			eas_pkg::PH_DUMMY: begin
				chip_select = 1'b1;
				bit_count_d = BCW'(DATA_BITS);
				phase_d     = eas_pkg::PH_SAMPLE;
			end
			eas_pkg::PH_SAMPLE: begin
				chip_select = 1'b1;
				shift_in_d  = {shift_in_d[DATA_BITS-2:0], data_in_pin};
				bit_count_d = bc_dec;
				if (bc_dec == '0)
					phase_d = eas_pkg::PH_DONE_OK;
			end
			eas_pkg::PH_GAP: begin
				phase_d = eas_pkg::PH_CHECK1;
			end
			eas_pkg::PH_CHECK1: begin
				chip_select = 1'b1;
				phase_d     = eas_pkg::PH_CHECK2;
			end
			eas_pkg::PH_CHECK2: begin
				chip_select  = 1'b1;
				poll_count_d = '0;
				phase_d      = data_in_pin ? eas_pkg::PH_CHECK3 : eas_pkg::PH_POLL;
			end
			eas_pkg::PH_CHECK3: begin
				chip_select  = 1'b1;
				poll_count_d = '0;
				phase_d      = data_in_pin ? eas_pkg::PH_DONE_NOSTART
					: eas_pkg::PH_POLL;
			end
			eas_pkg::PH_POLL: begin
				chip_select = 1'b1;
				if (data_in_pin)
					phase_d = eas_pkg::PH_DONE_OK;
				else if (cnt >= {1'b0, poll_limit})
					phase_d = eas_pkg::PH_DONE_TIMEOUT;
				else
					poll_count_d = cnt[PW-1:0];
			end
			eas_pkg::PH_DONE_OK, eas_pkg::PH_DONE_NOSTART,
			eas_pkg::PH_DONE_TIMEOUT: begin
				done_res = 1'b1;
				if (ph == eas_pkg::PH_DONE_NOSTART)
					status = eas_pkg::ST_NOSTART;
				else if (ph == eas_pkg::PH_DONE_TIMEOUT)
					status = eas_pkg::ST_TIMEOUT;
				if (kind_d == eas_pkg::OP_READ)
					read_data = shift_in_d;
				phase_d = eas_pkg::PH_IDLE;
			end
			default: begin
				busy_res = 1'b0;
				phase_d  = eas_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= eas_pkg::PH_IDLE;
			kind_q       <= '0;
			shift_out_q  <= '0;
			bit_count_q  <= '0;
			shift_in_q   <= '0;
			poll_count_q <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			kind_q       <= kind_d;
			shift_out_q  <= shift_out_d;
			bit_count_q  <= bit_count_d;
			shift_in_q   <= shift_in_d;
			poll_count_q <= poll_count_d;
		end
	end

endmodule

FILE: design/serial_eeprom_access_sequencer_top.sv
// ----------------------------------------------------------------------------
// serial_eeprom_access_sequencer_top: 3-wire serial EEPROM master sequencer
// Input register, bit-period sequencer and result register.
// ----------------------------------------------------------------------------
// Each input transfer is one serial bit period and yields exactly one result
// transfer with the lines to drive, busy, done, read data and status. The
// block takes one item per clock cycle when the output side keeps up; an
// item passes through the input register and then the result register on
// its way out. The sequencer state advances once per item, so a command
// of N bit periods needs N input items. poll_limit is written through the
// cfg port, which is always ready, and should only change while no command
// is in progress.
module serial_eeprom_access_sequencer_top #(
	parameter int ADDRESS_BITS = eas_pkg::ADDRESS_BITS_DEFAULT,
	parameter int DATA_BITS    = eas_pkg::DATA_BITS_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [eas_pkg::POLL_BITS-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [eas_pkg::OPCODE_BITS-1:0]  opcode,
	input  logic [ADDRESS_BITS-1:0]          address,
	input  logic [DATA_BITS-1:0]             write_data,
	input  logic                             data_in_pin,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             chip_select,
	output logic                             data_out_pin,
	output logic                             busy_res,
	output logic                             done_res,
	output logic [DATA_BITS-1:0]             read_data,
	output logic [eas_pkg::STATUS_BITS-1:0]  status
);

	logic [eas_pkg::POLL_BITS-1:0]   poll_limit_q;
	logic                            valid_s1;
	logic [eas_pkg::OPCODE_BITS-1:0] opcode_s1;
	logic [ADDRESS_BITS-1:0]         address_s1;
	logic [DATA_BITS-1:0]            write_data_s1;
	logic                            pin_s1;
	logic                            advance;
	logic                            in_take;

	logic                            cs_c, dout_c, busy_c, done_c;
	logic [DATA_BITS-1:0]            rdata_c;
	logic [eas_pkg::STATUS_BITS-1:0] status_c;

	assign cfg_ready = 1'b1;

	// The stage 1 item moves on when the result register is empty or is
	// being emptied by a transfer in this cycle.
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= eas_pkg::POLL_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			poll_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1     <= opcode;
			address_s1    <= address;
			write_data_s1 <= write_data;
			pin_s1        <= data_in_pin;
		end
	end

	eas_core #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.DATA_BITS   (DATA_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.opcode      (opcode_s1),
		.address     (address_s1),
		.write_data  (write_data_s1),
		.data_in_pin (pin_s1),
		.poll_limit  (poll_limit_q),
		.chip_select (cs_c),
		.data_out_pin(dout_c),
		.busy_res    (busy_c),
		.done_res    (done_c),
		.read_data   (rdata_c),
		.status      (status_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			chip_select  <= cs_c;
			data_out_pin <= dout_c;
			busy_res     <= busy_c;
			done_res     <= done_c;
			read_data    <= rdata_c;
			status       <= status_c;
		end
	end

endmodule
